@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL (included by hc_mult).
// Each macro takes a label, a clock and a property; HC_ASSERT also takes an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked property, disabled while reset is asserted.
`define HC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hill cipher assertion failed");

// Checked property that also holds during reset.
`define HC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hill cipher assertion failed");

`else

`define HC_ASSERT(lbl, clk, rstn, prop)
`define HC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hw/rtl/hc_pkg.sv @@
package hc_pkg;

  // Alphabet size and the letter used to pad a lone final letter.
  localparam logic [4:0] Alpha     = 5'd26;
  localparam logic [4:0] PadLetter = 5'd23;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgKeyR0C0 = 3'd0,
    CfgKeyR0C1 = 3'd1,
    CfgKeyR1C0 = 3'd2,
    CfgKeyR1C1 = 3'd3,
    CfgMode    = 3'd4
  } cfg_idx_e;

  // A completed pair of letters waiting for the multiply.
  typedef struct packed {
    logic [4:0] p0;
    logic [4:0] p1;
    logic       last;
  } pair_t;

  // Matrix in force and the error flag that goes with it.
  typedef struct packed {
    logic [3:0][4:0] m;
    logic            err;
  } key_t;

  // Reduce a 5-bit value to 0..25.
  function automatic logic [4:0] red26(input logic [4:0] v);
    red26 = (v >= Alpha) ? 5'(v - Alpha) : v;
  endfunction

  // Reduce an 11-bit value mod 26: reciprocal multiply, then one correction.
  function automatic logic [4:0] mod26(input logic [10:0] v);
    logic [19:0] prod;
    logic [6:0]  quo;
    logic [10:0] rem;
    prod = 20'(v) * 20'd315;
    quo  = prod[19:13];
    rem  = v - 11'(11'(quo) * 11'(Alpha));
    if (rem >= 11'(Alpha)) begin
      rem = rem - 11'(Alpha);
    end
    mod26 = rem[4:0];
  endfunction

  // Additive inverse mod 26 of a reduced value.
  function automatic logic [4:0] neg26(input logic [4:0] v);
    neg26 = (v == 5'd0) ? 5'd0 : 5'(Alpha - v);
  endfunction

  // Multiplicative inverse mod 26; zero when none exists.
  function automatic logic [4:0] inv26(input logic [4:0] d);
    case (d)
      5'd1:    inv26 = 5'd1;
      5'd3:    inv26 = 5'd9;
      5'd5:    inv26 = 5'd21;
      5'd7:    inv26 = 5'd15;
      5'd9:    inv26 = 5'd3;
      5'd11:   inv26 = 5'd19;
      5'd15:   inv26 = 5'd7;
      5'd17:   inv26 = 5'd23;
      5'd19:   inv26 = 5'd11;
      5'd21:   inv26 = 5'd5;
      5'd23:   inv26 = 5'd17;
      5'd25:   inv26 = 5'd25;
      default: inv26 = 5'd0;
    endcase
  endfunction

endpackage

@@ hw/rtl/hc_in_if.sv @@
// Letter input channel.
interface hc_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] letter_in;
  logic       end_of_message;

  modport source (output valid, output letter_in, output end_of_message, input ready);
  modport sink (input valid, input letter_in, input end_of_message, output ready);
endinterface

@@ hw/rtl/hc_out_if.sv @@
// Letter result channel.
interface hc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] letter_out;
  logic       last_out;
  logic       key_error;

  modport source (output valid, output letter_out, output last_out, output key_error,
                  input ready);
  modport sink (input valid, input letter_out, input last_out, input key_error,
                output ready);
endinterface

@@ hw/rtl/hill_cipher_2x2.sv @@
// Channel   Dir  Beat contents
// in_if     in   letter_in[4:0], end_of_message
// out_if    out  letter_out[4:0], last_out, key_error
// cfg       in   cfg_we_i, cfg_idx_i[2:0], cfg_wdata_i[4:0]
//
// One letter is taken per cycle unless stalled; a pair gives two result beats,
// one per cycle while out_if is ready; pair and result are registered in turn.
// A lone final letter is padded with the pad letter and yields two beats.
// A key write blocks input while the inverse key pipeline settles.
// Reset clears keys, mode and the held letter; the zero key has no inverse.
module hill_cipher_2x2 (
  input  logic       clk_i,
  input  logic       rst_ni,
  hc_in_if.sink      in_if,
  hc_out_if.source   out_if,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [4:0] cfg_wdata_i
);

  hc_pkg::key_t  mat;
  hc_pkg::pair_t pair;
  logic          busy;
  logic          pair_valid;
  logic          pair_take;

  hc_key u_key (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mat_o       (mat),
    .busy_o      (busy)
  );

  hc_pair u_pair (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .busy_i       (busy),
    .pair_take_i  (pair_take),
    .pair_valid_o (pair_valid),
    .pair_o       (pair)
  );

  hc_mult u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_valid_i (pair_valid),
    .pair_i       (pair),
    .mat_i        (mat),
    .pair_take_o  (pair_take),
    .out_if       (out_if)
  );

endmodule

@@ hw/rtl/hc_key.sv @@
// Key registers, mode register and the two-stage inverse key computation.
module hc_key (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [4:0]      cfg_wdata_i,
  output hc_pkg::key_t    mat_o,
  output logic            busy_o
);

  logic [3:0][4:0] key_q, key_d;
  logic            mode_q, mode_d;
  logic [1:0]      pend_q, pend_d;
  logic [4:0]      det_q, det_d;
  logic [3:0][4:0] inv_q, inv_d;
  logic            inv_ok_q, inv_ok_d;
  logic [4:0]      prod_ad, prod_bc;
  logic [4:0]      inv_det;

  // Register writes; keys are stored reduced to 0..25.
  always_comb begin
    key_d     = key_q;
    mode_d    = mode_q;
    pend_d    = {pend_q[0], 1'b0};
    if (cfg_we_i) begin
      case (hc_pkg::cfg_idx_e'(cfg_idx_i))
        hc_pkg::CfgKeyR0C0, hc_pkg::CfgKeyR0C1,
        hc_pkg::CfgKeyR1C0, hc_pkg::CfgKeyR1C1: begin
          key_d[cfg_idx_i[1:0]] = hc_pkg::red26(cfg_wdata_i);
          pend_d[0]             = 1'b1;
        end
        hc_pkg::CfgMode: begin
          mode_d = cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // First stage: determinant reduced to 0..25.
  always_comb begin
    prod_ad = hc_pkg::mod26(11'(10'(key_q[0]) * 10'(key_q[3])));
    prod_bc = hc_pkg::mod26(11'(10'(key_q[1]) * 10'(key_q[2])));
    det_d   = (prod_ad >= prod_bc) ? 5'(prod_ad - prod_bc) :
                                     5'(prod_ad + hc_pkg::Alpha - prod_bc);
  end

  // Second stage: adjugate scaled by the inverse determinant.
  always_comb begin
    inv_det  = hc_pkg::inv26(det_q);
    inv_ok_d = (inv_det != 5'd0);
    inv_d[0] = hc_pkg::mod26(11'(10'(key_q[3]) * 10'(inv_det)));
    inv_d[1] = hc_pkg::mod26(11'(10'(hc_pkg::neg26(key_q[1])) * 10'(inv_det)));
    inv_d[2] = hc_pkg::mod26(11'(10'(hc_pkg::neg26(key_q[2])) * 10'(inv_det)));
    inv_d[3] = hc_pkg::mod26(11'(10'(key_q[0]) * 10'(inv_det)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      mode_q   <= 1'b0;
      pend_q   <= '0;
      det_q    <= '0;
      inv_q    <= '0;
      inv_ok_q <= 1'b0;
    end else begin
      key_q    <= key_d;
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      det_q    <= det_d;
      inv_q    <= inv_d;
      inv_ok_q <= inv_ok_d;
    end
  end

  // Matrix in force for the multiply.
  assign mat_o.m   = mode_q ? inv_q : key_q;
  assign mat_o.err = mode_q & ~inv_ok_q;
  assign busy_o    = |pend_q;

endmodule

@@ hw/rtl/hc_pair.sv @@
// Groups letters into pairs and holds one completed pair for the multiply.
module hc_pair (
  input  logic          clk_i,
  input  logic          rst_ni,
  hc_in_if.sink         in_if,
  input  logic          busy_i,
  input  logic          pair_take_i,
  output logic          pair_valid_o,
  output hc_pkg::pair_t pair_o
);

  logic          half_q, half_d;
  logic [4:0]    held_q, held_d;
  logic          pair_v_q, pair_v_d;
  hc_pkg::pair_t pair_q, pair_d;
  logic          in_fire;
  logic [4:0]    letter;

  assign in_if.ready = ~busy_i & (~pair_v_q | pair_take_i);
  assign in_fire     = in_if.valid & in_if.ready;
  assign letter      = hc_pkg::red26(in_if.letter_in);

  // Hold a first letter, or complete a pair (padding a lone final letter).
  always_comb begin
    half_d   = half_q;
    held_d   = held_q;
    pair_d   = pair_q;
    pair_v_d = pair_v_q & ~pair_take_i;
    if (in_fire) begin
      if (half_q) begin
        pair_d.p0   = held_q;
        pair_d.p1   = letter;
        pair_d.last = in_if.end_of_message;
        pair_v_d    = 1'b1;
        half_d      = 1'b0;
      end else if (in_if.end_of_message) begin
        pair_d.p0   = letter;
        pair_d.p1   = hc_pkg::PadLetter;
        pair_d.last = 1'b1;
        pair_v_d    = 1'b1;
      end else begin
        held_d = letter;
        half_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= 1'b0;
      held_q   <= '0;
      pair_v_q <= 1'b0;
    end else begin
      half_q   <= half_d;
      held_q   <= held_d;
      pair_v_q <= pair_v_d;
    end
  end

  // Pair payload needs no reset.
  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  assign pair_valid_o = pair_v_q;
  assign pair_o       = pair_q;

endmodule

@@ hw/rtl/hc_mult.sv @@
`include "assert_macros.svh"

// Multiplies a pair by the matrix mod 26 and sends the two letters as two beats.
module hc_mult (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pair_valid_i,
  input  hc_pkg::pair_t pair_i,
  input  hc_pkg::key_t  mat_i,
  output logic          pair_take_o,
  hc_out_if.source      out_if
);

  logic       res_v_q, res_v_d;
  logic       idx_q, idx_d;
  logic [4:0] r0_q, r1_q, r0_d, r1_d;
  logic       err_q, last_q;
  logic       out_fire;
  logic       res_free;
  logic [9:0] pr00, pr01, pr10, pr11;

  assign out_fire    = out_if.valid & out_if.ready;
  assign res_free    = ~res_v_q | (out_fire & idx_q);
  assign pair_take_o = pair_valid_i & res_free;

  // Matrix times pair, each row reduced mod 26.
  always_comb begin
    pr00 = 10'(mat_i.m[0]) * 10'(pair_i.p0);
    pr01 = 10'(mat_i.m[1]) * 10'(pair_i.p1);
    pr10 = 10'(mat_i.m[2]) * 10'(pair_i.p0);
    pr11 = 10'(mat_i.m[3]) * 10'(pair_i.p1);
    r0_d = hc_pkg::mod26(11'(pr00) + 11'(pr01));
    r1_d = hc_pkg::mod26(11'(pr10) + 11'(pr11));
    if (mat_i.err) begin
      r0_d = '0;
      r1_d = '0;
    end
  end

  // Result register control: two beats per pair.
  always_comb begin
    res_v_d = res_v_q;
    idx_d   = idx_q;
    if (out_fire) begin
      if (idx_q) begin
        res_v_d = 1'b0;
        idx_d   = 1'b0;
      end else begin
        idx_d = 1'b1;
      end
    end
    if (pair_take_o) begin
      res_v_d = 1'b1;
      idx_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      res_v_q <= res_v_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_take_o) begin
      r0_q   <= r0_d;
      r1_q   <= r1_d;
      err_q  <= mat_i.err;
      last_q <= pair_i.last;
    end
  end

  assign out_if.valid      = res_v_q;
  assign out_if.letter_out = idx_q ? r1_q : r0_q;
  assign out_if.last_out   = idx_q & last_q;
  assign out_if.key_error  = err_q;

  // The first beat of a pair is always followed by the second.
  `HC_ASSERT(a_second_beat, clk_i, rst_ni, (out_fire && !idx_q) |=> (res_v_q && idx_q))
  // A key error result carries zero letters.
  `HC_ASSERT(a_err_zero, clk_i, rst_ni, (res_v_q && err_q) |-> (r0_q == '0 && r1_q == '0))
  // The message end marker only appears on the second beat of a pair.
  `HC_ASSERT(a_last_second, clk_i, rst_ni, (out_if.valid && out_if.last_out) |-> idx_q)
  // A new pair is loaded only when the result register is free.
  `HC_ASSERT(a_take_free, clk_i, rst_ni, pair_take_o |-> (!res_v_q || (out_fire && idx_q)))

endmodule
